// ===== design/rhks_pkg.sv =====
// package for the rendezvous hash k-select unit
// holds sizes, hash constants, status codes, state enum and control structs
package rhks_pkg;
  localparam int MAX_SERVERS = 16;
  localparam int MAX_PICKS = 8;
  localparam int SLOT_W = $clog2(MAX_SERVERS);
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int PICK_W = $clog2(MAX_PICKS);
  localparam int PCNT_W = $clog2(MAX_PICKS + 1);

  localparam logic [63:0] HASH_SEED = 64'h388b9301c3cd063c;
  localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;
  localparam logic [63:0] H_INIT = HASH_SEED + PR5 + 64'd16;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DUP = 2'd3;

  localparam logic OP_ADD = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_HASH, S_INS, S_EMIT, S_DONE
  } state_t;

  // hash unit micro-op
  typedef enum logic [3:0] {
    H_M0, H_M1, H_M2, H_M3, H_M4, H_M5, H_M6, H_M7, H_F0, H_F1, H_F2, H_F3
  } hstep_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic add_write;
    logic hash_start;
    logic hash_step;
    logic ins;
    logic emit;
    logic emit_add;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic scan_end;
    logic dup;
    logic full;
    logic zero_cnt;
    logic hash_done;
    logic last_slot;
    logic emit_last;
  } stat_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction
endpackage

// ===== design/rhks_mul.sv =====
// 64 x 64 low product built from three 32 x 32 partials
// depends on rhks_pkg
module rhks_mul (
  input  logic        clk,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p,
  output logic        done
);
  import rhks_pkg::*;
  logic [1:0] ph;
  logic       run;
  logic [31:0] x, y;
  logic [63:0] part;

  always_comb begin
    x = a[31:0];
    y = b[31:0];
    unique case (ph)
      2'd0: begin x = a[31:0]; y = b[31:0]; end
      2'd1: begin x = a[63:32]; y = b[31:0]; end
      2'd2: begin x = a[31:0]; y = b[63:32]; end
      default: begin x = a[31:0]; y = b[31:0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    part <= 64'(x) * 64'(y);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      run <= 1'b1;
      ph <= 2'd0;
    end else if (run) begin
      ph <= ph + 2'd1;
      unique case (ph)
        2'd0: ;
        2'd1: p <= part;
        2'd2: p <= p + {part[31:0], 32'd0};
        default: begin
          p <= p + {part[31:0], 32'd0};
          run <= 1'b0;
          done <= 1'b1;
        end
      endcase
    end else begin
      ph <= 2'd0;
    end
  end
endmodule

// ===== design/rhks_datapath.sv =====
// datapath: server table, hash unit, sorted lowest-k list, result registers
// depends on rhks_pkg and rhks_mul
module rhks_datapath (
  input  logic              clk,
  input  logic              rst,
  input  rhks_pkg::cmd_t    cmd,
  output rhks_pkg::stat_t   stat,
  input  logic              op,
  input  logic [63:0]       server_id,
  input  logic [63:0]       route_key,
  input  logic [3:0]        picks_per_key,
  output logic [1:0]        status,
  output logic [63:0]       chosen_id,
  output logic [3:0]        chosen_slot,
  output logic [63:0]       weight,
  output logic              last,
  output logic              done
);
  import rhks_pkg::*;
  logic [63:0] table_mem [MAX_SERVERS];
  logic [CNT_W-1:0] server_count;
  logic r_op;
  logic [63:0] r_sid, r_key;
  logic [PCNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [SLOT_W-1:0] dup_slot;
  logic dup;
  logic [63:0] cur_id;
  logic [63:0] bw [MAX_PICKS];
  logic [SLOT_W-1:0] bs [MAX_PICKS];
  logic [PCNT_W-1:0] filled;
  logic [PCNT_W-1:0] eidx;
  logic [63:0] h, acc;
  hstep_t hs;
  logic mstart, mdone;
  logic [63:0] ma, mb, mp;
  logic hdone;
  logic [PCNT_W-1:0] pk;

  rhks_mul u_mul (.clk(clk), .start(mstart), .a(ma), .b(mb), .p(mp), .done(mdone));

  always_comb begin
    pk = (picks_per_key > 4'(MAX_PICKS)) ? PCNT_W'(MAX_PICKS) : PCNT_W'(picks_per_key);
  end

  assign stat.is_add = r_op == OP_ADD;
  assign stat.scan_end = idx >= server_count;
  assign stat.dup = dup;
  assign stat.full = server_count >= CNT_W'(MAX_SERVERS);
  assign stat.zero_cnt = count == '0;
  assign stat.hash_done = hdone;
  assign stat.last_slot = idx + CNT_W'(1) >= server_count;
  assign stat.emit_last = eidx + PCNT_W'(1) >= count;

  always_ff @(posedge clk) begin
    cur_id <= table_mem[idx[SLOT_W-1:0]];
    if (cmd.add_write) table_mem[server_count[SLOT_W-1:0]] <= r_sid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= '0;
    end else if (cmd.add_write) begin
      server_count <= server_count + CNT_W'(1);
    end
  end

  // the hash is a chain of multiplies through the shared unit
  always_comb begin
    ma = acc;
    mb = PR2;
    unique case (hs)
      H_M0, H_M4: mb = PR2;
      H_M1, H_M3, H_M5, H_M7: mb = PR1;
      H_F1: mb = PR2;
      H_F3: mb = PR3;
      default: mb = PR2;
    endcase
  end

  always_ff @(posedge clk) begin
    mstart <= 1'b0;
    hdone <= 1'b0;
    if (cmd.load) begin
      r_op <= op;
      r_sid <= server_id;
      r_key <= route_key;
      idx <= '0;
      dup <= 1'b0;
      dup_slot <= '0;
      filled <= '0;
      eidx <= '0;
      count <= (CNT_W'(pk) > server_count) ? PCNT_W'(server_count) : pk;
    end
    if (cmd.scan_step) begin
      if (!dup && idx < server_count && table_mem[idx[SLOT_W-1:0]] == r_sid) begin
        dup <= 1'b1;
        dup_slot <= idx[SLOT_W-1:0];
      end
      if (!(idx >= server_count)) idx <= idx + CNT_W'(1);
    end
    if (cmd.hash_start) begin
      acc <= r_key;
      h <= H_INIT;
      hs <= H_M0;
      mstart <= 1'b1;
    end else if (cmd.hash_step && mdone) begin
      unique case (hs)
        H_M0, H_M4: begin acc <= rotl(mp, 31); hs <= hstep_t'(hs + 4'd1); mstart <= 1'b1; end
        H_M1, H_M5: begin
          acc <= rotl(h ^ mp, 27);
          hs <= hstep_t'(hs + 4'd2);
          mstart <= 1'b1;
        end
        H_M3: begin
          h <= mp + PR4;
          acc <= cur_id;
          hs <= H_M4;
          mstart <= 1'b1;
        end
        H_M7: begin
          acc <= (mp + PR4) ^ ((mp + PR4) >> 33);
          hs <= H_F1;
          mstart <= 1'b1;
        end
        H_F1: begin acc <= mp ^ (mp >> 29); hs <= H_F3; mstart <= 1'b1; end
        H_F3: begin h <= mp ^ (mp >> 32); hdone <= 1'b1; hs <= H_F0; end
        default: ;
      endcase
    end
    if (cmd.ins) begin
      for (int j = 0; j < MAX_PICKS; j++) begin
        logic lt, ltp;
        lt = (PCNT_W'(j) >= filled) || (h < bw[j]);
        ltp = (j == 0) ? 1'b0 : ((PCNT_W'(j - 1) >= filled) || (h < bw[j-1]));
        if (PCNT_W'(j) < count && lt) begin
          if (ltp && j > 0) begin
            bw[j] <= bw[j-1];
            bs[j] <= bs[j-1];
          end else begin
            bw[j] <= h;
            bs[j] <= idx[SLOT_W-1:0];
          end
        end
      end
      if (filled < count) filled <= filled + PCNT_W'(1);
      idx <= idx + CNT_W'(1);
    end
    if (cmd.emit) eidx <= eidx + PCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit || cmd.emit_add;
    end
  end

  always_ff @(posedge clk) begin
    last <= 1'b1;
    if (cmd.emit_add) begin
      chosen_id <= r_sid;
      weight <= '0;
      if (r_op == OP_ADD) begin
        status <= dup ? ST_DUP : (stat.full ? ST_FULL : ST_OK);
        chosen_slot <= dup ? 4'(dup_slot) : (stat.full ? 4'd0 : 4'(server_count));
      end else begin
        status <= ST_NONE;
        chosen_id <= '0;
        chosen_slot <= '0;
      end
    end else if (cmd.emit) begin
      status <= ST_OK;
      chosen_slot <= 4'(bs[eidx[PICK_W-1:0]]);
      chosen_id <= table_mem[bs[eidx[PICK_W-1:0]]];
      weight <= bw[eidx[PICK_W-1:0]];
      last <= stat.emit_last;
    end
  end
endmodule

// ===== design/rhks_ctrl.sv =====
// controller state machine sequencing add scans, hashing and emission
// depends on rhks_pkg
module rhks_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  rhks_pkg::stat_t stat,
  output rhks_pkg::cmd_t  cmd
);
  import rhks_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = state != S_IDLE;
    unique case (state)
      S_IDLE: if (start) begin
        cmd.load = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!stat.is_add) begin
          if (stat.zero_cnt) begin
            cmd.emit_add = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.hash_start = 1'b1;
            state_next = S_HASH;
          end
        end else if (stat.scan_end) begin
          cmd.emit_add = 1'b1;
          cmd.add_write = !stat.dup && !stat.full;
          state_next = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.hash_done) state_next = S_INS;
      end
      S_INS: begin
        cmd.ins = 1'b1;
        if (stat.last_slot) state_next = S_EMIT;
        else state_next = S_SCAN;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_last) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== design/rendezvous_hash_k_select_unit.sv =====
// top level of the rendezvous hash k-select unit
// depends on rhks_pkg, rhks_ctrl, rhks_datapath
// An add request scans the table one slot per cycle and gives one result.
// A route request hashes each stored id through one shared 64-bit multiplier built from
// 32 x 32 partials, eight products a hash, then emits one result per cycle. Results
// appear on a one-cycle strobe and cannot be held off; busy is high until the last result
// of a request is out.
module rendezvous_hash_k_select_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        op,
  input  logic [63:0] server_id,
  input  logic [63:0] route_key,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] chosen_id,
  output logic [3:0]  chosen_slot,
  output logic [63:0] weight,
  output logic        last
);
  import rhks_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic [3:0] picks_per_key;

  always_ff @(posedge clk) begin
    if (rst) picks_per_key <= 4'd3;
    else if (cfg_we) picks_per_key <= cfg_data;
  end

  rhks_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd));

  rhks_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .op(op), .server_id(server_id),
    .route_key(route_key), .picks_per_key(picks_per_key), .status(status),
    .chosen_id(chosen_id), .chosen_slot(chosen_slot), .weight(weight), .last(last),
    .done(done)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not latched");
  a_one_cycle_emit: assert property (@(posedge clk) disable iff (rst)
    (done && last) |=> !done) else $error("result after last");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !(done && !last)) else $error("stray result");
endmodule
